/* hdl/itp_pkg.sv */
// Shared types, codes and helper functions for the infix-to-postfix converter.
package itp_pkg;

  localparam int CMD_W = 3;
  localparam int OP_W = 3;
  localparam int KIND_W = 3;
  localparam int ERR_W = 2;
  localparam int PREC_W = 15;
  localparam int ASSOC_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [CMD_W-1:0] CMD_OPERAND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_OPERATOR = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LPAREN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RPAREN = 3'd3;
  localparam logic [CMD_W-1:0] CMD_END = 3'd4;

  localparam logic [OP_W-1:0] OP_MAX = 3'd4;
  localparam logic [OP_W-1:0] PAREN_MARK = 3'd5;

  localparam logic [KIND_W-1:0] KIND_OPERAND = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 3'd2;
  localparam logic [KIND_W-1:0] KIND_END = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PREC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ASSOC = 1'b1;

  localparam logic [PREC_W-1:0] PREC_RESET = 15'd22730;
  localparam logic [ASSOC_W-1:0] ASSOC_RESET = 5'd10;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);
  localparam int Q_LW = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [OP_W-1:0]  code;
  } tok_t;

  localparam int TOK_W = $bits(tok_t);

  function automatic logic [2:0] prec_of(input logic [PREC_W-1:0] tbl,
                                         input logic [OP_W-1:0] code);
    logic [2:0] p;
    case (code)
      3'd0: p = tbl[2:0];
      3'd1: p = tbl[5:3];
      3'd2: p = tbl[8:6];
      3'd3: p = tbl[11:9];
      3'd4: p = tbl[14:12];
      default: p = tbl[2:0];
    endcase
    return p;
  endfunction

  function automatic logic is_left(input logic [ASSOC_W-1:0] mask,
                                   input logic [OP_W-1:0] code);
    logic l;
    case (code)
      3'd0: l = mask[0];
      3'd1: l = mask[1];
      3'd2: l = mask[2];
      3'd3: l = mask[3];
      3'd4: l = mask[4];
      default: l = mask[0];
    endcase
    return l;
  endfunction

endpackage

/* hdl/itp_front.sv */
// Input stage: accepts tokens, drops malformed ones and forwards the rest to the queue.
module itp_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  itp_pkg::tok_t           in_tok,
  input  logic [VALUE_WIDTH-1:0]  in_value,
  output logic                    q_push,
  input  logic                    q_ready,
  output itp_pkg::tok_t           q_tok,
  output logic [VALUE_WIDTH-1:0]  q_value
);
  import itp_pkg::*;

  logic                   hold_valid_r;
  logic                   hold_valid_nxt;
  tok_t                   hold_tok_r;
  logic [VALUE_WIDTH-1:0] hold_value_r;
  logic                   keep;
  logic                   take;

  always_comb begin
    case (in_tok.cmd)
      CMD_OPERAND: keep = 1'b1;
      CMD_OPERATOR: keep = (in_tok.code <= OP_MAX);
      CMD_LPAREN: keep = 1'b1;
      CMD_RPAREN: keep = 1'b1;
      CMD_END: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = !hold_valid_r || q_ready;
  assign take = in_valid && in_ready;
  assign q_push = hold_valid_r;
  assign q_tok = hold_tok_r;
  assign q_value = hold_value_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (take) begin
      hold_valid_nxt = keep;
    end else if (q_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_tok_r <= in_tok;
      hold_value_r <= in_value;
    end
  end

endmodule

/* hdl/itp_queue.sv */
// Short token queue between the input stage and the stack engine.
module itp_queue #(
  parameter int WIDTH = 38
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     ready,
  input  logic [WIDTH-1:0]         push_data,
  input  logic                     pop,
  output logic                     valid,
  output logic [WIDTH-1:0]         pop_data,
  output logic [itp_pkg::Q_LW-1:0] level
);
  import itp_pkg::*;

  logic [WIDTH-1:0] mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r;
  logic [Q_AW-1:0]  wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r;
  logic [Q_AW-1:0]  rd_ptr_nxt;
  logic [Q_LW-1:0]  level_r;
  logic [Q_LW-1:0]  level_nxt;
  logic             do_push;
  logic             do_pop;

  assign ready = (level_r != Q_LW'(Q_DEPTH));
  assign valid = (level_r != '0);
  assign pop_data = mem[rd_ptr_r];
  assign level = level_r;
  assign do_push = push && ready;
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt = level_r;
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/itp_back.sv */
// Stack engine: runs the operator stack and drives the registered result stage.
module itp_back #(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [itp_pkg::PREC_W-1:0]      prec_tbl,
  input  logic [itp_pkg::ASSOC_W-1:0]     assoc_mask,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  itp_pkg::tok_t                   q_tok,
  input  logic [VALUE_WIDTH-1:0]          q_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [itp_pkg::KIND_W-1:0]      out_kind,
  output logic [itp_pkg::OP_W-1:0]        out_operator,
  output logic [VALUE_WIDTH-1:0]          out_value,
  output logic                            out_last,
  output logic [itp_pkg::ERR_W-1:0]       out_error
);
  import itp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN = 1'b1;

  logic [OP_W-1:0]        mem [STACK_DEPTH];
  logic                   state_r;
  logic                   state_nxt;
  tok_t                   cur_tok_r;
  logic [VALUE_WIDTH-1:0] cur_value_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic [OP_W-1:0]        top_r;
  logic [OP_W-1:0]        top_nxt;
  logic [OP_W-1:0]        rd_r;
  logic                   rd_ok_r;
  logic                   rd_ok_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [KIND_W-1:0]      out_kind_r;
  logic [OP_W-1:0]        out_op_r;
  logic [VALUE_WIDTH-1:0] out_value_r;
  logic                   out_last_r;
  logic [ERR_W-1:0]       out_err_r;

  logic                   can_emit;
  logic                   rd_rdy;
  logic                   has_top;
  logic                   has_two;
  logic                   full;
  logic                   top_paren;
  logic                   pops_top;
  logic                   next_pops;
  logic [2:0]             pc;
  logic [2:0]             pt;
  logic [2:0]             pn;
  logic                   emit;
  logic [KIND_W-1:0]      e_kind;
  logic [OP_W-1:0]        e_op;
  logic [VALUE_WIDTH-1:0] e_value;
  logic                   e_last;
  logic [ERR_W-1:0]       e_err;
  logic                   do_pop;
  logic                   do_push;
  logic [OP_W-1:0]        push_val;
  logic                   done;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;
  logic [CW-1:0]          count_m1;
  logic [CW-1:0]          count_m2;

  assign can_emit = !out_valid_r || out_ready;
  assign has_top = (count_r != '0);
  assign has_two = (count_r >= CW'(2));
  assign rd_rdy = !has_two || rd_ok_r;
  assign full = (count_r == CW'(STACK_DEPTH));
  assign top_paren = (top_r == PAREN_MARK);
  assign pc = prec_of(prec_tbl, cur_tok_r.code);
  assign pt = prec_of(prec_tbl, top_r);
  assign pn = prec_of(prec_tbl, rd_r);
  assign pops_top = has_top && !top_paren &&
                    ((pt > pc) || ((pt == pc) && is_left(assoc_mask, top_r)));
  assign next_pops = has_two && (rd_r != PAREN_MARK) &&
                     ((pn > pc) || ((pn == pc) && is_left(assoc_mask, rd_r)));
  assign count_m1 = count_r - CW'(1);
  assign count_m2 = count_r - CW'(2);
  assign wr_addr = count_m1[AW-1:0];
  assign rd_addr = count_m2[AW-1:0];

  always_comb begin
    emit = 1'b0;
    e_kind = KIND_OPERAND;
    e_op = '0;
    e_value = '0;
    e_last = 1'b0;
    e_err = ERR_NONE;
    do_pop = 1'b0;
    do_push = 1'b0;
    push_val = cur_tok_r.code;
    done = 1'b0;
    if (state_r == S_RUN) begin
      case (cur_tok_r.cmd)
        CMD_OPERAND: begin
          if (can_emit) begin
            emit = 1'b1;
            e_value = cur_value_r;
            e_last = 1'b1;
            done = 1'b1;
          end
        end
        CMD_OPERATOR: begin
          if (pops_top) begin
            if (can_emit && rd_rdy) begin
              emit = 1'b1;
              e_kind = KIND_OPERATOR;
              e_op = top_r;
              e_last = !next_pops;
              do_pop = 1'b1;
            end
          end else if (full) begin
            if (can_emit) begin
              emit = 1'b1;
              e_kind = KIND_ERROR;
              e_err = ERR_OVERFLOW;
              e_last = 1'b1;
              done = 1'b1;
            end
          end else begin
            do_push = 1'b1;
            done = 1'b1;
          end
        end
        CMD_LPAREN: begin
          push_val = PAREN_MARK;
          if (full) begin
            if (can_emit) begin
              emit = 1'b1;
              e_kind = KIND_ERROR;
              e_err = ERR_OVERFLOW;
              e_last = 1'b1;
              done = 1'b1;
            end
          end else begin
            do_push = 1'b1;
            done = 1'b1;
          end
        end
        CMD_RPAREN: begin
          if (!has_top) begin
            if (can_emit) begin
              emit = 1'b1;
              e_kind = KIND_ERROR;
              e_err = ERR_UNMATCHED;
              e_last = 1'b1;
              done = 1'b1;
            end
          end else if (top_paren) begin
            if (rd_rdy) begin
              do_pop = 1'b1;
              done = 1'b1;
            end
          end else if (can_emit && rd_rdy) begin
            emit = 1'b1;
            e_kind = KIND_OPERATOR;
            e_op = top_r;
            e_last = has_two && (rd_r == PAREN_MARK);
            do_pop = 1'b1;
          end
        end
        CMD_END: begin
          if (!has_top) begin
            if (can_emit) begin
              emit = 1'b1;
              e_kind = KIND_END;
              e_last = 1'b1;
              done = 1'b1;
            end
          end else if (can_emit && rd_rdy) begin
            emit = 1'b1;
            e_kind = top_paren ? KIND_LPAREN : KIND_OPERATOR;
            e_op = top_paren ? '0 : top_r;
            do_pop = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  assign q_pop = q_valid && ((state_r == S_IDLE) || done);
  assign wr_en = do_push && has_top;

  always_comb begin
    state_nxt = state_r;
    if (q_pop) begin
      state_nxt = S_RUN;
    end else if (done) begin
      state_nxt = S_IDLE;
    end
    count_nxt = count_r;
    top_nxt = top_r;
    if (do_pop) begin
      count_nxt = count_m1;
      top_nxt = rd_r;
    end else if (do_push) begin
      count_nxt = count_r + CW'(1);
      top_nxt = push_val;
    end
    rd_ok_nxt = !do_pop && !do_push;
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rd_ok_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rd_ok_r <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (q_pop) begin
      cur_tok_r <= q_tok;
      cur_value_r <= q_value;
    end
    if (emit) begin
      out_kind_r <= e_kind;
      out_op_r <= e_op;
      out_value_r <= e_value;
      out_last_r <= e_last;
      out_err_r <= e_err;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top_r;
    end
    rd_r <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_operator = out_op_r;
  assign out_value = out_value_r;
  assign out_last = out_last_r;
  assign out_error = out_err_r;

endmodule

/* hdl/infix_to_postfix_converter_top.sv */
// Top level of the infix-to-postfix converter: configuration registers and stage wiring.
//
// Tokens enter on the in_ channel, one per transaction: in_tuser carries the
// command, in_tdata the operator code and the operand value. Malformed tokens
// are dropped without a result. Postfix results leave on the out_ channel;
// out_tuser is the result kind and out_tlast marks the final result of a token.
// An input stage feeds a four-entry queue, and a stack engine drains it.
// The input side takes one token per cycle until the queue fills.
// A pop that leaves at least one entry behind waits when it directly follows
// another push or pop, because the entry below the top comes from a
// registered read of the stack memory. On its way to the output a token
// passes the input stage's holding register, the queue, the stack engine's
// current-token register and the result register.
// Precedence and associativity are written on the cfg_ port; the user must
// do so only while idle, as the block itself does not enforce it.
// After reset the stack is empty and both registers hold their default values.
// When the receiver stalls, the result register holds its transaction, the
// engine waits, the queue fills and in_tready falls.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // operator_code, operand_value, zero padding
  input  logic [((VALUE_WIDTH+10)/8)*8-1:0]      in_tdata,
  // command
  input  logic [itp_pkg::CMD_W-1:0]              in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // out_operator, out_value, error_code, zero padding
  output logic [((VALUE_WIDTH+12)/8)*8-1:0]      out_tdata,
  // out_kind
  output logic [itp_pkg::KIND_W-1:0]             out_tuser,
  output logic                                   out_tlast,
  input  logic                                   cfg_wr_en,
  input  logic [itp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [itp_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import itp_pkg::*;

  localparam int OUT_W = ((VALUE_WIDTH + 12) / 8) * 8;
  localparam int QW = TOK_W + VALUE_WIDTH;

  logic [PREC_W-1:0]      prec_r;
  logic [PREC_W-1:0]      prec_nxt;
  logic [ASSOC_W-1:0]     assoc_r;
  logic [ASSOC_W-1:0]     assoc_nxt;
  tok_t                   in_tok;
  logic                   q_push;
  logic                   q_ready;
  tok_t                   f_tok;
  logic [VALUE_WIDTH-1:0] f_value;
  logic                   q_pop;
  logic                   q_valid;
  logic [QW-1:0]          q_data;
  tok_t                   q_tok;
  logic [VALUE_WIDTH-1:0] q_value;
  logic [Q_LW-1:0]        q_level;
  logic [KIND_W-1:0]      r_kind;
  logic [OP_W-1:0]        r_op;
  logic [VALUE_WIDTH-1:0] r_value;
  logic [ERR_W-1:0]       r_err;

  always_comb begin
    prec_nxt = prec_r;
    assoc_nxt = assoc_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_PREC: prec_nxt = cfg_wdata[PREC_W-1:0];
        REG_ASSOC: assoc_nxt = cfg_wdata[ASSOC_W-1:0];
        default: prec_nxt = prec_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r <= PREC_RESET;
      assoc_r <= ASSOC_RESET;
    end else begin
      prec_r <= prec_nxt;
      assoc_r <= assoc_nxt;
    end
  end

  assign in_tok.cmd = in_tuser;
  assign in_tok.code = in_tdata[OP_W-1:0];

  itp_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_tok   (in_tok),
    .in_value (in_tdata[OP_W +: VALUE_WIDTH]),
    .q_push   (q_push),
    .q_ready  (q_ready),
    .q_tok    (f_tok),
    .q_value  (f_value)
  );

  itp_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .ready     (q_ready),
    .push_data ({f_value, f_tok}),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data),
    .level     (q_level)
  );

  assign q_tok = q_data[TOK_W-1:0];
  assign q_value = q_data[QW-1:TOK_W];

  itp_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .prec_tbl     (prec_r),
    .assoc_mask   (assoc_r),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_tok        (q_tok),
    .q_value      (q_value),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (r_kind),
    .out_operator (r_op),
    .out_value    (r_value),
    .out_last     (out_tlast),
    .out_error    (r_err)
  );

  assign out_tuser = r_kind;
  assign out_tdata = OUT_W'({r_err, r_value, r_op});

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_ERROR)) |-> out_tlast)
    else $error("error result without last flag");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_END)) |-> out_tlast)
    else $error("end marker without last flag");

  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_ready && !q_pop) |=> (q_level != '0))
    else $error("queue lost a pushed token");

  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != KIND_ERROR)) |-> (r_err == ERR_NONE))
    else $error("error code set on a non-error result");

endmodule
